@@ sv/pid_position_controller_defines.svh @@
// ---------------------------------------------------------------------------
// pid_position_controller_defines
// assertion macros shared by the position controller
// ---------------------------------------------------------------------------
`ifndef PID_POSITION_CONTROLLER_DEFINES_SVH
`define PID_POSITION_CONTROLLER_DEFINES_SVH

// check that is switched off while reset is high
`define PID_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds across reset
`define PID_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/pidpos_pkg.sv @@
// ---------------------------------------------------------------------------
// pidpos_pkg
// register codes and fixed field widths of the position controller
// ---------------------------------------------------------------------------
package pidpos_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int GAIN_W    = 16;
  localparam int LIMIT_W   = 23;
  localparam int TOL_W     = 16;
  localparam int SPEED_W   = 15;
  localparam int DRIVE_W   = 16;
  localparam int ISUM_W    = LIMIT_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INTEG_GAIN     = 3'd1,
    REG_DERIV_GAIN     = 3'd2,
    REG_INTEGRAL_LIMIT = 3'd3,
    REG_DONE_TOLERANCE = 3'd4,
    REG_SPEED_CEILING  = 3'd5,
    REG_SPEED_FLOOR    = 3'd6,
    REG_GOAL_DISTANCE  = 3'd7
  } cfg_reg_t;

  localparam logic [LIMIT_W-1:0] LIMIT_RST   = 23'd8388607;
  localparam logic [TOL_W-1:0]   TOL_RST     = 16'd128;
  localparam logic [SPEED_W-1:0] CEILING_RST = 15'd23040;
  localparam logic [SPEED_W-1:0] FLOOR_RST   = 15'd10240;

endpackage

@@ sv/pid_position_controller.sv @@
// ---------------------------------------------------------------------------
// pid_position_controller
// position pid loop with clamped integral and saturated drive
// ---------------------------------------------------------------------------
// One measured distance beat in gives one drive beat out. A beat can be taken
// every cycle unless the output stalls; results pass through four registered
// stages: error, integral clamp and derivative with the loop state update,
// then the three gain multiplies, then their sum, then rounding, speed limits
// and the output register. Stages close up bubbles, so input beats keep being
// taken while a result waits at the output until all four stages are full.
// Write gains, limits and the goal through the configuration port only while
// no beat is in flight; the block does not enforce it. Index 0 to 7 select
// prop gain, integral gain, derivative gain, integral limit, done tolerance,
// speed ceiling, speed floor and goal distance. After reset the loop is
// finished and gives zero drive with done set until a beat carries start_req.
`include "pid_position_controller_defines.svh"

module pid_position_controller #(
  parameter int DIST_WIDTH     = 24,
  parameter int GAIN_FRAC_BITS = 12,
  localparam int CFG_W = (DIST_WIDTH > pidpos_pkg::LIMIT_W) ? DIST_WIDTH
                                                           : pidpos_pkg::LIMIT_W
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pidpos_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]                       cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   start_req,
  input  logic signed [DIST_WIDTH-1:0]           measured_distance,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [pidpos_pkg::DRIVE_W-1:0]  drive_command,
  output logic                                   done_res
);
  import pidpos_pkg::*;

  localparam int EW  = DIST_WIDTH + 1;
  localparam int DVW = DIST_WIDTH + 2;
  localparam int SW  = ((EW > ISUM_W) ? EW : ISUM_W) + 1;
  localparam int PPW = GAIN_W + 1 + EW;
  localparam int PIW = GAIN_W + 1 + ISUM_W;
  localparam int PDW = GAIN_W + 1 + DVW;
  localparam int AW  = ((PDW > PIW) ? PDW : PIW) + 2;
  localparam int MW  = AW + 1 - GAIN_FRAC_BITS;
  localparam logic [AW:0] HALF = (AW+1)'(1) << (GAIN_FRAC_BITS - 1);

  // configuration
  logic [GAIN_W-1:0]            prop_gain, integ_gain, deriv_gain;
  logic [LIMIT_W-1:0]           integral_limit;
  logic [TOL_W-1:0]             done_tolerance;
  logic [SPEED_W-1:0]           speed_ceiling, speed_floor;
  logic signed [DIST_WIDTH-1:0] goal_distance;

  // loop state
  logic signed [ISUM_W-1:0] error_sum;
  logic signed [EW-1:0]     prior_error;
  logic                     finished;

  // pipeline
  logic                     s1_valid, s2_valid, s3_valid;
  logic                     s1_load, s2_load, s3_load, out_load;
  logic                     s1_idle, s2_idle, s3_idle;
  logic                     s1_done, s2_done, s3_done;
  logic signed [EW-1:0]     s1_err;
  logic signed [ISUM_W-1:0] s1_isum;
  logic signed [DVW-1:0]    s1_deriv;
  logic signed [PPW-1:0]    s2_pprop;
  logic signed [PIW-1:0]    s2_pinteg;
  logic signed [PDW-1:0]    s2_pderiv;
  logic signed [AW-1:0]     s3_acc;

  // stage 1 logic
  logic                     fin_eff, in_take, within_tol;
  logic signed [ISUM_W-1:0] es_eff, isum;
  logic signed [EW-1:0]     pe_eff, err;
  logic [EW-1:0]            err_abs;
  logic signed [SW-1:0]     sum_raw, lim_pos, lim_neg;
  logic signed [DVW-1:0]    deriv;

  // output stage logic
  logic                     acc_neg, acc_zero;
  logic [AW-1:0]            acc_abs;
  logic [AW:0]              acc_rnd;
  logic [MW-1:0]            mag;
  logic [SPEED_W-1:0]       mag_sel;
  logic signed [DRIVE_W-1:0] drive;
  logic [DRIVE_W-1:0]       drive_abs;

  assign cfg_ready = 1'b1;

  assign out_load = !out_valid || out_ready;
  assign s3_load  = !s3_valid || out_load;
  assign s2_load  = !s2_valid || s3_load;
  assign s1_load  = !s1_valid || s2_load;
  assign in_ready = s1_load;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    fin_eff = start_req ? 1'b0 : finished;
    es_eff  = start_req ? '0 : error_sum;
    pe_eff  = start_req ? EW'(goal_distance) : prior_error;
    err     = EW'(goal_distance) - EW'(measured_distance);
    err_abs = err[EW-1] ? EW'(-err) : EW'(err);
    within_tol = err_abs <= EW'(done_tolerance);
    sum_raw = SW'(es_eff) + SW'(err);
    lim_pos = SW'(integral_limit);
    lim_neg = -lim_pos;
    if (sum_raw > lim_pos) begin
      isum = ISUM_W'(lim_pos);
    end else if (sum_raw < lim_neg) begin
      isum = ISUM_W'(lim_neg);
    end else begin
      isum = ISUM_W'(sum_raw);
    end
    deriv = DVW'(err) - DVW'(pe_eff);
  end

  always_comb begin
    acc_neg  = s3_acc[AW-1];
    acc_zero = s3_acc == '0;
    acc_abs  = acc_neg ? AW'(-s3_acc) : AW'(s3_acc);
    acc_rnd  = {1'b0, acc_abs} + HALF;
    mag      = MW'(acc_rnd >> GAIN_FRAC_BITS);
    if (acc_zero || s3_idle) begin
      mag_sel = '0;
    end else if (mag > MW'(speed_ceiling)) begin
      mag_sel = speed_ceiling;
    end else if (mag < MW'(speed_floor)) begin
      mag_sel = speed_floor;
    end else begin
      mag_sel = mag[SPEED_W-1:0];
    end
    drive = acc_neg ? -DRIVE_W'(mag_sel) : DRIVE_W'(mag_sel);
    drive_abs = drive_command[DRIVE_W-1] ? DRIVE_W'(-drive_command)
                                         : DRIVE_W'(drive_command);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain      <= '0;
      integ_gain     <= '0;
      deriv_gain     <= '0;
      integral_limit <= LIMIT_RST;
      done_tolerance <= TOL_RST;
      speed_ceiling  <= CEILING_RST;
      speed_floor    <= FLOOR_RST;
      goal_distance  <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_PROP_GAIN:      prop_gain      <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN:     integ_gain     <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:     deriv_gain     <= cfg_data[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[LIMIT_W-1:0];
        REG_DONE_TOLERANCE: done_tolerance <= cfg_data[TOL_W-1:0];
        REG_SPEED_CEILING:  speed_ceiling  <= cfg_data[SPEED_W-1:0];
        REG_SPEED_FLOOR:    speed_floor    <= cfg_data[SPEED_W-1:0];
        REG_GOAL_DISTANCE:  goal_distance  <= cfg_data[DIST_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // loop state moves on at the input beat, so the next beat sees it at once
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum   <= '0;
      prior_error <= '0;
      finished    <= 1'b1;
    end else if (in_take && !fin_eff) begin
      error_sum   <= isum;
      prior_error <= err;
      finished    <= within_tol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= in_valid;
      end
      if (s2_load) begin
        s2_valid <= s1_valid;
      end
      if (s3_load) begin
        s3_valid <= s2_valid;
      end
      if (out_load) begin
        out_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_err   <= err;
      s1_isum  <= isum;
      s1_deriv <= deriv;
      s1_idle  <= fin_eff;
      s1_done  <= fin_eff || within_tol;
    end
    if (s2_load) begin
      s2_pprop  <= $signed({1'b0, prop_gain}) * s1_err;
      s2_pinteg <= $signed({1'b0, integ_gain}) * s1_isum;
      s2_pderiv <= $signed({1'b0, deriv_gain}) * s1_deriv;
      s2_idle   <= s1_idle;
      s2_done   <= s1_done;
    end
    if (s3_load) begin
      s3_acc  <= AW'(s2_pprop) + AW'(s2_pinteg) + AW'(s2_pderiv);
      s3_idle <= s2_idle;
      s3_done <= s2_done;
    end
    if (out_load) begin
      drive_command <= drive;
      done_res      <= s3_done;
    end
  end

  `PID_CHECK_RST(a_reset_empties, rst |=> !out_valid, "output valid after reset")
  `PID_CHECK(a_integral_bound, error_sum != {1'b1, {LIMIT_W{1'b0}}}, "integral out of range")
  `PID_CHECK(a_drive_bound, out_valid |-> (drive_abs <= DRIVE_W'(speed_ceiling) || drive_abs == DRIVE_W'(speed_floor)), "drive beyond limits")

endmodule
